@@ sv/lzss_flag_byte_decoder_defines.svh @@
`ifndef LZSS_FLAG_BYTE_DECODER_DEFINES_SVH
`define LZSS_FLAG_BYTE_DECODER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LZSSD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define LZSSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/lzssd_pkg.sv @@
package lzssd_pkg;

  localparam int HIST_AW = 12;
  localparam int HIST_DEPTH = 1 << HIST_AW;
  localparam int CNT_W = 5;
  localparam logic [CNT_W-1:0] LEN_BASE = 5'd18;
  localparam logic [3:0] FLAGS_PER_BYTE = 4'd8;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    TK_NONE,
    TK_LIT,
    TK_COPY,
    TK_END
  } tok_t;

  typedef struct packed {
    tok_t kind;
    logic out_free;
    logic cnt_last;
  } dp_status_t;

  typedef struct packed {
    logic take;
    logic emit_lit;
    logic rd_first;
    logic emit_cp;
    logic emit_end;
    logic done;
  } dp_cmd_t;

endpackage

@@ sv/lzssd_ctrl.sv @@
module lzssd_ctrl
  import lzssd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LIT,
    S_CP_RD,
    S_CP_WR,
    S_END
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.take = in_valid;
        if (in_valid) begin
          unique case (status.kind)
            TK_LIT:  state_nxt = S_LIT;
            TK_COPY: state_nxt = S_CP_RD;
            TK_END:  state_nxt = S_END;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_LIT: begin
        if (status.out_free) begin
          cmd.emit_lit = 1'b1;
          cmd.done = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_CP_RD: begin
        cmd.rd_first = 1'b1;
        state_nxt = S_CP_WR;
      end
      S_CP_WR: begin
        if (status.out_free) begin
          cmd.emit_cp = 1'b1;
          if (status.cnt_last) begin
            cmd.done = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_END: begin
        if (status.out_free) begin
          cmd.emit_end = 1'b1;
          cmd.done = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ sv/lzssd_dp.sv @@
module lzssd_dp
  import lzssd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_byte,
  input  logic        in_final_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_run_last,
  output logic        out_stream_end,
  output logic [15:0] out_consumed,
  input  dp_cmd_t     cmd,
  output dp_status_t  status
);

  typedef enum logic [1:0] {
    PH_FLAG,
    PH_TOKEN,
    PH_REF2
  } phase_t;

  phase_t             phase_r;
  logic [7:0]         flag_bits_r;
  logic [3:0]         flags_left_r;
  logic [7:0]         ref_high_r;
  logic [HIST_AW-1:0] wp_r;
  logic               ended_r;
  logic [15:0]        byte_count_r;
  logic               fin_r;
  logic [7:0]         hold_r;
  logic [HIST_AW-1:0] off_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [7:0]         rdata_r;
  logic [7:0]         last_r;
  logic               fwd_r;
  logic               out_valid_r;
  logic [7:0]         out_byte_r;
  logic               out_run_last_r;
  logic               out_stream_end_r;
  logic [15:0]        out_consumed_r;

  logic [7:0]         hist_mem [HIST_DEPTH];

  tok_t               kind;
  logic [HIST_AW-1:0] offset;
  logic [CNT_W-1:0]   len;
  logic [3:0]         flags_left_dec;
  logic               out_free;
  logic               restart;
  logic               mem_we;
  logic [7:0]         mem_wdata;
  logic               rd_en;
  logic [HIST_AW-1:0] rd_base;
  logic [HIST_AW-1:0] rd_addr;
  logic [7:0]         cp_data;

  assign offset = {ref_high_r[7:4], in_byte};
  assign len = LEN_BASE - {1'b0, ref_high_r[3:0]};
  assign flags_left_dec = (flags_left_r != 4'd0) ? flags_left_r - 4'd1 : 4'd0;

  always_comb begin
    kind = TK_NONE;
    if (!ended_r) begin
      case (phase_r)
        PH_TOKEN: kind = flag_bits_r[7] ? TK_LIT : TK_NONE;
        PH_REF2:  kind = (offset == '0) ? TK_END : TK_COPY;
        default:  kind = TK_NONE;
      endcase
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign status.kind = kind;
  assign status.out_free = out_free;
  assign status.cnt_last = (cnt_r == CNT_W'(1));

  assign restart = (cmd.take && (kind == TK_NONE) && in_final_byte) || (cmd.done && fin_r);

  // offset of one reads the entry written in the same cycle
  assign cp_data = fwd_r ? last_r : rdata_r;
  assign mem_we = cmd.emit_lit || cmd.emit_cp;
  assign mem_wdata = cmd.emit_lit ? hold_r : cp_data;
  assign rd_en = cmd.rd_first || (cmd.emit_cp && !status.cnt_last);
  assign rd_base = cmd.emit_cp ? wp_r + HIST_AW'(1) : wp_r;
  assign rd_addr = rd_base - off_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist_mem[wp_r] <= mem_wdata;
    end
    if (rd_en) begin
      rdata_r <= hist_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FLAG;
      flag_bits_r <= '0;
      flags_left_r <= '0;
      ref_high_r <= '0;
      wp_r <= '0;
      ended_r <= 1'b0;
      byte_count_r <= '0;
      fin_r <= 1'b0;
      fwd_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.take) begin
        fin_r <= in_final_byte;
      end

      if (restart) begin
        phase_r <= PH_FLAG;
        flag_bits_r <= '0;
        flags_left_r <= '0;
        ref_high_r <= '0;
        wp_r <= '0;
        ended_r <= 1'b0;
        byte_count_r <= '0;
      end else begin
        if (cmd.take && !ended_r) begin
          if (byte_count_r != COUNT_MAX) begin
            byte_count_r <= byte_count_r + 16'd1;
          end
          case (phase_r)
            PH_TOKEN: begin
              flag_bits_r <= {flag_bits_r[6:0], 1'b0};
              flags_left_r <= flags_left_dec;
              if (flag_bits_r[7]) begin
                hold_r <= in_byte;
                phase_r <= (flags_left_dec == 4'd0) ? PH_FLAG : PH_TOKEN;
              end else begin
                ref_high_r <= in_byte;
                phase_r <= PH_REF2;
              end
            end
            PH_REF2: begin
              if (offset == '0) begin
                ended_r <= 1'b1;
              end else begin
                off_r <= offset;
                cnt_r <= len;
                phase_r <= (flags_left_r == 4'd0) ? PH_FLAG : PH_TOKEN;
              end
            end
            default: begin
              flag_bits_r <= in_byte;
              flags_left_r <= FLAGS_PER_BYTE;
              phase_r <= PH_TOKEN;
            end
          endcase
        end
        if (mem_we) begin
          wp_r <= wp_r + HIST_AW'(1);
        end
      end

      if (cmd.emit_cp) begin
        last_r <= cp_data;
        cnt_r <= cnt_r - CNT_W'(1);
      end
      if (rd_en) begin
        fwd_r <= cmd.emit_cp && (off_r == HIST_AW'(1));
      end

      if (cmd.emit_lit || cmd.emit_cp || cmd.emit_end) begin
        out_valid_r <= 1'b1;
        out_byte_r <= cmd.emit_lit ? hold_r : (cmd.emit_cp ? cp_data : 8'd0);
        out_run_last_r <= cmd.done;
        out_stream_end_r <= cmd.emit_end;
        out_consumed_r <= byte_count_r;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte = out_byte_r;
  assign out_run_last = out_run_last_r;
  assign out_stream_end = out_stream_end_r;
  assign out_consumed = out_consumed_r;

endmodule

@@ sv/lzss_flag_byte_decoder.sv @@
// channel  direction  handshake             payload
// in       input      in_valid / in_stall   in_byte, in_final_byte
// out      output     out_valid / out_stall out_byte, out_run_last, out_stream_end, out_consumed
// flag byte, first reference byte or ignored byte: taken in S_IDLE, no item out
// literal: taken in S_IDLE, history write and output register load in S_LIT
// end token: taken in S_IDLE, output register load in S_END
// reference: S_IDLE, S_CP_RD, then S_CP_WR (length 3..18), one history read and write a cycle unless out_stall holds
// reset: synchronous rst_n low, history contents stay undefined until written
// out_stall holds the output register and the copy loop in place
module lzss_flag_byte_decoder
  import lzssd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_final_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_run_last,
  output logic        out_stream_end,
  output logic [15:0] out_consumed
);

`include "lzss_flag_byte_decoder_defines.svh"

  dp_cmd_t    cmd;
  dp_status_t status;

  lzssd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  lzssd_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_byte        (in_byte),
    .in_final_byte  (in_final_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_run_last   (out_run_last),
    .out_stream_end (out_stream_end),
    .out_consumed   (out_consumed),
    .cmd            (cmd),
    .status         (status)
  );

  `LZSSD_ASSERT_NOW(a_end_is_last, out_valid && out_stream_end, out_run_last, "end item not last")
  `LZSSD_ASSERT_NOW(a_end_zero, out_valid && out_stream_end, out_byte == 8'd0, "end item not zero")
  `LZSSD_ASSERT_NOW(a_run_blocks_in, out_valid && !out_run_last, in_stall, "input taken mid run")
  `LZSSD_ASSERT_NEXT(a_done_frees_in, cmd.done, !in_stall, "input blocked after item done")

endmodule
